FILE: src/lht_pkg.sv
package lht_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam logic [7:0] PROBE_LIMIT_RESET = 8'd10;

    typedef enum logic [1:0] {
        CMD_GET    = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_REPLACED = 3'd1,
        ST_ABSENT   = 3'd2,
        ST_GOT      = 3'd3,
        ST_CROWDED  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_WAIT,
        S_EVAL,
        S_SCAN_RD,
        S_SCAN_WAIT,
        S_SCAN_EVAL,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic addr_home;
        logic addr_leap;
        logic addr_scan;
        logic rd;
        logic wr_fill;
        logic wr_value;
        logic wr_absent;
        logic wr_link;
        logic out_load;
        status_t out_status;
        logic out_hit;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic empty;
        logic match;
        logic present;
        logic leap_zero;
        logic steps_max;
        logic scan_last;
        logic hash_zero;
        cmd_t cmd;
    } stat_t;

endpackage

FILE: src/lht_datapath.sv
module lht_datapath
    import lht_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  ctrl_t        ctrl,
    output stat_t        stat,
    input  logic [1:0]   in_cmd,
    input  logic [63:0]  in_hash,
    input  logic [63:0]  in_key,
    input  logic [63:0]  in_value,
    input  logic [7:0]   probe_limit,
    output logic [2:0]   out_status,
    output logic         out_found,
    output logic [63:0]  out_value
);
    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [63:0] hash_mem [TABLE_ENTRIES];
    logic [63:0] key_mem [TABLE_ENTRIES];
    logic [63:0] val_mem [TABLE_ENTRIES];
    logic        pres_mem [TABLE_ENTRIES];
    logic [7:0]  long_mem [TABLE_ENTRIES];
    logic [7:0]  short_mem [TABLE_ENTRIES];

    logic [1:0]  cmd_reg;
    logic [63:0] hash_reg, key_reg, value_reg;
    logic [AW-1:0] idx_reg, idx_next, home_reg, end_reg, clr_reg, addr;
    logic [AW:0] steps_reg;
    logic [7:0]  off_reg;
    logic [63:0] rd_hash, rd_key, rd_val;
    logic        rd_pres;
    logic [7:0]  rd_long, rd_short, leap;

    assign leap = (steps_reg == '0) ? rd_long : rd_short;
    assign addr = ctrl.clr_wr ? clr_reg : idx_reg;

    always_comb
    begin
        idx_next = idx_reg;
        if (ctrl.addr_home)
            idx_next = in_hash[AW-1:0];
        else if (ctrl.addr_leap)
            idx_next = idx_reg + AW'(leap);
        else if (ctrl.addr_scan)
            idx_next = end_reg + AW'(off_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (ctrl.clr_wr)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= in_cmd;
            hash_reg  <= in_hash;
            key_reg   <= in_key;
            value_reg <= in_value;
            home_reg  <= in_hash[AW-1:0];
            steps_reg <= '0;
        end
        idx_reg <= idx_next;
        if (ctrl.addr_leap)
            steps_reg <= steps_reg + 1'b1;
        if (ctrl.addr_scan)
            off_reg <= off_reg + 8'd1;
        else if (ctrl.load || ctrl.addr_leap)
        begin
            off_reg <= 8'd1;
            end_reg <= idx_next;
        end
        if (ctrl.rd)
        begin
            rd_hash  <= hash_mem[idx_reg];
            rd_key   <= key_mem[idx_reg];
            rd_val   <= val_mem[idx_reg];
            rd_pres  <= pres_mem[idx_reg];
            rd_long  <= long_mem[idx_reg];
            rd_short <= short_mem[idx_reg];
        end
        if (ctrl.clr_wr)
        begin
            hash_mem[addr]  <= '0;
            pres_mem[addr]  <= 1'b0;
            long_mem[addr]  <= '0;
            short_mem[addr] <= '0;
        end
        if (ctrl.wr_fill)
        begin
            hash_mem[idx_reg] <= hash_reg;
            key_mem[idx_reg]  <= key_reg;
            long_mem[idx_reg] <= '0;
            short_mem[idx_reg] <= '0;
        end
        if (ctrl.wr_fill || ctrl.wr_value)
        begin
            val_mem[idx_reg]  <= value_reg;
            pres_mem[idx_reg] <= 1'b1;
        end
        if (ctrl.wr_absent)
            pres_mem[idx_reg] <= 1'b0;
        if (ctrl.wr_link)
        begin
            if (end_reg == home_reg)
                long_mem[end_reg] <= off_reg - 8'd1;
            else
                short_mem[end_reg] <= off_reg - 8'd1;
        end
        if (ctrl.out_load)
        begin
            out_status <= ctrl.out_status;
            out_found  <= ctrl.out_hit;
            out_value  <= ctrl.out_hit ? rd_val : 64'd0;
        end
    end

    assign stat.clr_last  = (clr_reg == AW'(TABLE_ENTRIES - 1));
    assign stat.empty     = (rd_hash == 64'd0);
    assign stat.match     = (rd_hash == hash_reg) && (rd_key == key_reg);
    assign stat.present   = rd_pres;
    assign stat.leap_zero = (leap == 8'd0);
    assign stat.steps_max = (steps_reg == (AW+1)'(TABLE_ENTRIES - 1));
    assign stat.scan_last = (off_reg >= probe_limit);
    assign stat.hash_zero = (hash_reg == 64'd0);
    assign stat.cmd       = cmd_t'(cmd_reg);
endmodule

FILE: src/lht_ctrl.sv
module lht_ctrl
    import lht_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_fire,
    input  logic  out_busy,
    input  logic  out_fire,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  in_ready,
    output logic  out_valid
);
    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        ctrl.out_status = ST_ABSENT;
        ov_next = ov_reg && !out_fire;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctrl.clr_wr = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctrl.addr_home = 1'b1;
                if (in_fire)
                begin
                    ctrl.load = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (stat.hash_zero || stat.cmd == CMD_NONE)
                begin
                    ctrl.out_status = (stat.cmd == CMD_GET) ? ST_GOT :
                                      (stat.cmd == CMD_INSERT) ? ST_CROWDED : ST_ABSENT;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.rd = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
                state_next = S_EVAL;
            S_EVAL:
            begin
                if (stat.empty)
                begin
                    if (stat.cmd == CMD_INSERT)
                    begin
                        ctrl.wr_fill = 1'b1;
                        ctrl.out_status = ST_STORED;
                    end
                    else
                        ctrl.out_status = (stat.cmd == CMD_GET) ? ST_GOT : ST_ABSENT;
                    state_next = S_DONE;
                end
                else if (stat.match)
                begin
                    if (stat.cmd == CMD_INSERT)
                    begin
                        ctrl.wr_value = 1'b1;
                        ctrl.out_status = ST_REPLACED;
                    end
                    else if (stat.cmd == CMD_DELETE)
                    begin
                        ctrl.wr_absent = 1'b1;
                        ctrl.out_status = ST_ABSENT;
                    end
                    else
                    begin
                        ctrl.out_status = ST_GOT;
                        ctrl.out_hit = stat.present;
                    end
                    state_next = S_DONE;
                end
                else if (stat.leap_zero || stat.steps_max)
                begin
                    if (stat.cmd == CMD_INSERT)
                    begin
                        ctrl.addr_scan = 1'b1;
                        state_next = S_SCAN_RD;
                        if (stat.scan_last)
                        begin
                            ctrl.out_status = ST_CROWDED;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        ctrl.out_status = (stat.cmd == CMD_GET) ? ST_GOT : ST_ABSENT;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ctrl.addr_leap = 1'b1;
                    state_next = S_RD;
                end
            end
            S_SCAN_RD:
            begin
                ctrl.rd = 1'b1;
                state_next = S_SCAN_WAIT;
            end
            S_SCAN_WAIT:
                state_next = S_SCAN_EVAL;
            S_SCAN_EVAL:
            begin
                if (stat.empty)
                begin
                    ctrl.wr_fill = 1'b1;
                    ctrl.wr_link = 1'b1;
                    ctrl.out_status = ST_STORED;
                    state_next = S_DONE;
                end
                else if (stat.scan_last)
                begin
                    ctrl.out_status = ST_CROWDED;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.addr_scan = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    state_next = S_IDLE;
                    ov_next = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        // hold the finishing step until the previous result item is taken
        if (state_next == S_DONE && state_reg != S_DONE)
        begin
            if (out_busy)
            begin
                ctrl = '0;
                state_next = state_reg;
            end
            else
                ctrl.out_load = 1'b1;
        end
    end
endmodule

FILE: src/leapfrog_hash_table_unit.sv
// Leapfrog-probing hash table of TABLE_ENTRIES slots, one command item in, one result item
// out. A controller walks the key's leap chain and, for an insert, then a linear scan for a
// free slot; each visited slot takes a read state, a wait state for the registered memory
// read and an evaluate state. A zero hash or an unknown command skips the memory. While a
// result item is not taken, the next item waits before its last step. After reset a
// clearing pass over all TABLE_ENTRIES slots runs before the first item is taken.
module leapfrog_hash_table_unit
    import lht_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // command
    input  logic [191:0] s_tdata,   // key_hash, key, value
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // status, found, value_out, zero fill
);
    logic [7:0]  probe_limit_reg;
    ctrl_t       ctrl;
    stat_t       stat;
    logic [2:0]  st_q;
    logic        found_q;
    logic [63:0] val_q;
    logic        in_fire, out_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            probe_limit_reg <= PROBE_LIMIT_RESET;
        else if (cfg_we)
            probe_limit_reg <= cfg_wdata;
    end

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    lht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .out_busy(m_tvalid && !m_tready), .out_fire(out_fire),
        .stat(stat), .ctrl(ctrl), .in_ready(s_tready), .out_valid(m_tvalid)
    );

    lht_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
        .in_cmd(s_tuser), .in_hash(s_tdata[63:0]), .in_key(s_tdata[127:64]),
        .in_value(s_tdata[191:128]), .probe_limit(probe_limit_reg),
        .out_status(st_q), .out_found(found_q), .out_value(val_q)
    );

    assign m_tdata = {4'd0, val_q, found_q, st_q};

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped");
    a_found_get: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2:0] == ST_GOT)
        else $error("found on non get");
endmodule

FILE: bench/tb_leapfrog_hash_table_unit.sv
module tb_leapfrog_hash_table_unit;
    import lht_pkg::*;

    localparam int SLOTS = TABLE_ENTRIES_DEF;
    localparam int WALK_EMPTY = 0;
    localparam int WALK_MATCH = 1;
    localparam int WALK_END = 2;
    localparam int STALL_LIMIT = 20000;
    localparam int POOL_SIZE = 96;

    typedef struct {
        status_t    status;
        logic       found;
        logic [63:0] value;
    } lookup_result_t;

    class lht_scoreboard;
        logic [63:0] slot_hash [SLOTS];
        logic [63:0] slot_key [SLOTS];
        logic [63:0] slot_value [SLOTS];
        logic        slot_present [SLOTS];
        logic [7:0]  long_leap [SLOTS];
        logic [7:0]  short_leap [SLOTS];
        logic [7:0]  probe_limit;
        lookup_result_t pending_results[$];
        int errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_hash[i] = '0;
                slot_key[i] = '0;
                slot_value[i] = '0;
                slot_present[i] = 1'b0;
                long_leap[i] = '0;
                short_leap[i] = '0;
            end
            probe_limit = PROBE_LIMIT_RESET;
            errors = 0;
        endfunction

        function int follow_chain(logic [63:0] h, logic [63:0] k, output int at);
            int idx;
            int steps;
            logic [7:0] jump;
            idx = int'(h & 64'(SLOTS - 1));
            steps = 0;
            forever
            begin
                at = idx;
                if (slot_hash[idx] == 0)
                    return WALK_EMPTY;
                if (slot_hash[idx] == h && slot_key[idx] == k)
                    return WALK_MATCH;
                jump = (steps == 0) ? long_leap[idx] : short_leap[idx];
                if (jump == 0)
                    return WALK_END;
                steps++;
                if (steps >= SLOTS)
                    return WALK_END;
                idx = (idx + int'(jump)) & (SLOTS - 1);
            end
        endfunction

        function void fill(int idx, logic [63:0] h, logic [63:0] k, logic [63:0] v);
            slot_hash[idx] = h;
            slot_key[idx] = k;
            slot_value[idx] = v;
            slot_present[idx] = 1'b1;
        endfunction

        function status_t insert_entry(logic [63:0] h, logic [63:0] k, logic [63:0] v);
            int idx;
            int home;
            int n;
            int r;
            home = int'(h & 64'(SLOTS - 1));
            r = follow_chain(h, k, idx);
            if (r == WALK_EMPTY)
            begin
                fill(idx, h, k, v);
                return ST_STORED;
            end
            if (r == WALK_MATCH)
            begin
                slot_value[idx] = v;
                slot_present[idx] = 1'b1;
                return ST_REPLACED;
            end
            for (int i = 1; i < int'(probe_limit); i++)
            begin
                n = (idx + i) & (SLOTS - 1);
                if (slot_hash[n] == 0)
                begin
                    fill(n, h, k, v);
                    if (idx == home)
                        long_leap[idx] = 8'(i);
                    else
                        short_leap[idx] = 8'(i);
                    return ST_STORED;
                end
            end
            return ST_CROWDED;
        endfunction

        function void note_item(cmd_t c, logic [63:0] h, logic [63:0] k, logic [63:0] v);
            lookup_result_t res;
            int idx;
            res.status = ST_ABSENT;
            res.found = 1'b0;
            res.value = '0;
            if (c == CMD_GET)
            begin
                res.status = ST_GOT;
                if (h != 0 && follow_chain(h, k, idx) == WALK_MATCH && slot_present[idx])
                begin
                    res.found = 1'b1;
                    res.value = slot_value[idx];
                end
            end
            else if (c == CMD_INSERT)
                res.status = (h == 0) ? ST_CROWDED : insert_entry(h, k, v);
            else if (c == CMD_DELETE)
            begin
                if (h != 0 && follow_chain(h, k, idx) == WALK_MATCH)
                    slot_present[idx] = 1'b0;
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [71:0] data);
            lookup_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item %h", data);
                return;
            end
            exp_res = pending_results.pop_front();
            if (data[2:0] !== exp_res.status || data[3] !== exp_res.found
                || data[67:4] !== exp_res.value || data[71:68] !== 4'b0)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected status %0d found %0d value %h, got %0d %0d %h",
                             exp_res.status, exp_res.found, exp_res.value,
                             data[2:0], data[3], data[67:4]);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [7:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;

    lht_scoreboard sb;
    int snd_idle;
    int rcv_idle;
    int hold_left;
    int quiet_cycles;
    logic [63:0] pool_hash [POOL_SIZE];
    logic [63:0] pool_key [POOL_SIZE];

    leapfrog_hash_table_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver, result check and watchdog
    initial
    begin
        m_tready = 1'b0;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    task automatic send_item(cmd_t c, logic [63:0] h, logic [63:0] k, logic [63:0] v);
        if ($urandom_range(0, 99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < snd_idle);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= {v, k, h};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(c, h, k, v);
    endtask

    task automatic drain();
        @(posedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_probe_limit(logic [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.probe_limit = v;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_item();
        int sel;
        int p;
        cmd_t c;
        logic [63:0] h;
        sel = $urandom_range(0, 99);
        p = $urandom_range(0, POOL_SIZE - 1);
        case ($urandom_range(0, 4))
            0, 1: c = CMD_INSERT;
            2, 3: c = CMD_GET;
            default: c = CMD_DELETE;
        endcase
        if (sel < 80)
            send_item(c, pool_hash[p], pool_key[p], rand64());
        else if (sel < 95)
        begin
            h = rand64();
            if (h == 0)
                h = 64'd1;
            send_item(c, h, rand64(), rand64());
        end
        else if (sel < 98)
            send_item(c, 64'd0, rand64(), rand64());
        else
            send_item(CMD_NONE, pool_hash[p], pool_key[p], rand64());
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        snd_idle = 0;
        rcv_idle = 0;
        hold_left = 0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_key[i] = rand64();
            pool_hash[i] = {54'(rand64() >> 10), 10'($urandom_range(1, 47))};
            if (i % 2 == 1 && $urandom_range(0, 3) == 0)
                pool_hash[i] = pool_hash[i - 1];
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        send_item(CMD_GET, 64'd1, 64'd0, 64'd0);
        send_item(CMD_INSERT, 64'd1, 64'd0, 64'd0);
        send_item(CMD_INSERT, '1, '1, '1);
        send_item(CMD_GET, 64'd1, 64'd0, '1);
        send_item(CMD_GET, '1, '1, 64'd0);
        send_item(CMD_INSERT, '1, '1, 64'h0123_4567_89ab_cdef);
        send_item(CMD_DELETE, '1, '1, 64'd0);
        send_item(CMD_GET, '1, '1, 64'd0);
        send_item(CMD_DELETE, '1, '1, 64'd0);
        send_item(CMD_INSERT, '1, '1, 64'hfedc_ba98_7654_3210);
        send_item(CMD_GET, '1, '1, 64'd0);
        send_item(CMD_GET, 64'd0, 64'd0, 64'd0);
        send_item(CMD_INSERT, 64'd0, 64'd5, 64'd5);
        send_item(CMD_DELETE, 64'd0, 64'd5, 64'd5);
        send_item(CMD_NONE, 64'd1, 64'd0, 64'd0);
        for (int i = 0; i < 5; i++)
            send_item(CMD_INSERT, 64'h0000_0001_0000_0201 + (64'(i) << 40),
                      64'(i + 100), 64'(i));
        send_item(CMD_INSERT, 64'h0000_0001_0000_0201, 64'd777, 64'd9);
        send_item(CMD_GET, 64'h0000_0401_0000_0201, 64'd104, 64'd0);
        send_item(CMD_GET, 64'h0000_0001_0000_0201, 64'd777, 64'd0);
        drain();
        write_probe_limit(8'd0);
        send_item(CMD_INSERT, 64'h0000_0002_0000_0201, 64'd1, 64'd1);
        drain();
        write_probe_limit(8'd1);
        send_item(CMD_INSERT, 64'h0000_0003_0000_0201, 64'd1, 64'd1);
        drain();

        // random phases
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_probe_limit(8'd2); snd_idle = 0; rcv_idle = 0; end
                1: begin write_probe_limit(8'd128); snd_idle = 50; rcv_idle = 0; end
                2: begin write_probe_limit(8'd10); snd_idle = 0; rcv_idle = 50; end
                3: begin write_probe_limit(8'($urandom_range(2, 128))); snd_idle = 37;
                         rcv_idle = 37; end
                default: begin write_probe_limit(8'd128); snd_idle = 0; rcv_idle = 0; end
            endcase
            for (int n = 0; n < 290; n++)
            begin
                if (ph == 0 && n == 20)
                    hold_left = 400;
                random_item();
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
